/* rtl/core/kct_pkg.sv */
// Shared types, codes and the fixed base translation table of the key code translator.
package kct_pkg;

  localparam int unsigned KeyW          = 23;
  localparam int unsigned ValW          = 25;
  localparam int unsigned CountW        = 7;
  localparam int unsigned OverrideDepth = 64;
  localparam int unsigned RomSize       = 54;
  localparam int unsigned RomIdxW       = 6;
  localparam logic [KeyW-1:0] AsciiLow  = KeyW'(32);
  localparam logic [KeyW-1:0] AsciiHigh = KeyW'(126);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TGT,
    ST_MOVE,
    ST_ROM,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [KeyW-1:0] key_in;
    logic [ValW-1:0] new_value;
  } kct_in_t;

  typedef struct packed {
    logic [ValW-1:0]   mapped_key;
    logic [1:0]        status;
    logic [CountW-1:0] override_count;
  } kct_out_t;

  // Base table, sorted by source code.
  localparam logic [KeyW-1:0] RomSrc [RomSize] = '{
    23'd4194305, 23'd4194306, 23'd4194307, 23'd4194308, 23'd4194309, 23'd4194310,
    23'd4194311, 23'd4194312, 23'd4194313, 23'd4194314, 23'd4194315, 23'd4194316,
    23'd4194317, 23'd4194318, 23'd4194319, 23'd4194320, 23'd4194321, 23'd4194322,
    23'd4194323, 23'd4194324, 23'd4194325, 23'd4194326, 23'd4194327, 23'd4194328,
    23'd4194329, 23'd4194330, 23'd4194331, 23'd4194332, 23'd4194333, 23'd4194334,
    23'd4194335, 23'd4194336, 23'd4194337, 23'd4194338, 23'd4194339, 23'd4194340,
    23'd4194341, 23'd4194342, 23'd4194343, 23'd4194433, 23'd4194434, 23'd4194435,
    23'd4194436, 23'd4194437, 23'd4194438, 23'd4194439, 23'd4194440, 23'd4194441,
    23'd4194442, 23'd4194443, 23'd4194444, 23'd4194445, 23'd4194446, 23'd4194447
  };

  localparam logic [ValW-1:0] RomDst [RomSize] = '{
    25'h1000000, 25'h1000001, 25'h1000002, 25'h1000003, 25'h1000004, 25'h1000005,
    25'h1000006, 25'h1000007, 25'h1000008, 25'h1000009, 25'h100000A, 25'h100000B,
    25'h1000010, 25'h1000011, 25'h1000012, 25'h1000013, 25'h1000014, 25'h1000015,
    25'h1000016, 25'h1000017, 25'h1000020, 25'h1000021, 25'h1000022, 25'h1000023,
    25'h1000024, 25'h1000025, 25'h1000026, 25'h1000030, 25'h1000031, 25'h1000032,
    25'h1000033, 25'h1000034, 25'h1000035, 25'h1000036, 25'h1000037, 25'h1000038,
    25'h1000039, 25'h100003A, 25'h100003B, 25'h000002A, 25'h000002F, 25'h000002D,
    25'h000002E, 25'h000002B, 25'h0000030, 25'h0000031, 25'h0000032, 25'h0000033,
    25'h0000034, 25'h0000035, 25'h0000036, 25'h0000037, 25'h0000038, 25'h0000039
  };

endpackage

/* rtl/core/kct_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module kct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/key_code_translation_table.sv */
// Key code translator: override table scan in RAM, printable pass-through, base table search.
// A word on the input carries an operation, a source key and a target code; every word
// yields exactly one result word with the translated code, a status and the override count.
// Overrides live in two RAMs (source and target) with registered reads; every operation but
// clear scans the live entries at one RAM read per cycle; a lookup that misses the overrides
// and is not a printable code (32 to 126) then goes on to a binary search of the base table.
// The input is taken only while the sequencer is idle; a finished result waits in the output
// register so the next word can start while it is unclaimed. No clearing pass after reset.
module key_code_translation_table
  import kct_pkg::*;
#(
  parameter int unsigned OVERRIDE_DEPTH = OverrideDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  kct_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output kct_out_t out_o
);

  localparam int unsigned IdxW = (OVERRIDE_DEPTH > 1) ? $clog2(OVERRIDE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(OVERRIDE_DEPTH + 1);

  typedef struct packed {
    logic [ValW-1:0] mapped;
    status_e         status;
  } res_t;

  state_e            state_q, state_d;
  kct_in_t           item_q;
  logic [CntW-1:0]   used_q, used_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]   hit_idx_q, hit_idx_d;
  logic [RomIdxW-1:0] lo_q, lo_d, hi_q, hi_d;
  res_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  kct_out_t          out_q, out_d;

  logic              src_we, tgt_we;
  logic [IdxW-1:0]   src_waddr, tgt_waddr, src_raddr, tgt_raddr;
  logic [KeyW-1:0]   src_wdata, src_rdata;
  logic [ValW-1:0]   tgt_wdata, tgt_rdata;

  logic              accept, load, match, is_ascii;
  logic [RomIdxW:0]  mid_sum;
  logic [RomIdxW-1:0] mid;
  logic [CntW-1:0]   last;
  logic [CntW+CountW-1:0] used_ext;

  kct_ram #(.WIDTH(KeyW), .DEPTH(OVERRIDE_DEPTH)) u_src_ram (
    .clk_i  (clk_i),
    .we_i   (src_we),
    .waddr_i(src_waddr),
    .wdata_i(src_wdata),
    .raddr_i(src_raddr),
    .rdata_o(src_rdata)
  );

  kct_ram #(.WIDTH(ValW), .DEPTH(OVERRIDE_DEPTH)) u_tgt_ram (
    .clk_i  (clk_i),
    .we_i   (tgt_we),
    .waddr_i(tgt_waddr),
    .wdata_i(tgt_wdata),
    .raddr_i(tgt_raddr),
    .rdata_o(tgt_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign match       = cmp_vld_q && (src_rdata == item_q.key_in);
  assign is_ascii    = (item_q.key_in >= AsciiLow) && (item_q.key_in <= AsciiHigh);
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = mid_sum[RomIdxW:1];
  assign last        = used_q - CntW'(1);
  assign used_ext    = {{CountW{1'b0}}, used_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      cmp_vld_q   <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
    end
    issue_q   <= issue_d;
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    issue_d   = issue_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    hit_idx_d = hit_idx_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    res_d     = res_q;
    load      = 1'b0;
    src_we    = 1'b0;
    tgt_we    = 1'b0;
    src_waddr = used_q[IdxW-1:0];
    tgt_waddr = used_q[IdxW-1:0];
    src_wdata = item_q.key_in;
    tgt_wdata = item_q.new_value;
    src_raddr = issue_q[IdxW-1:0];
    tgt_raddr = cmp_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        issue_d     = '0;
        res_d.mapped = '0;
        res_d.status = STAT_OK;
        if (accept) begin
          if (in_i.operation == OP_CLEAR) begin
            used_d  = '0;
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (match) begin
          priority case (item_q.operation)
            OP_LOOKUP: begin
              tgt_raddr = cmp_idx_q;
              state_d   = ST_TGT;
            end
            OP_ADD: begin
              tgt_we    = 1'b1;
              tgt_waddr = cmp_idx_q;
              state_d   = ST_RESP;
            end
            default: begin
              // fetch the last entry to fill the hole
              src_raddr = last[IdxW-1:0];
              tgt_raddr = last[IdxW-1:0];
              hit_idx_d = cmp_idx_q;
              state_d   = ST_MOVE;
            end
          endcase
        end else if (issue_q < used_q) begin
          src_raddr = issue_q[IdxW-1:0];
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[IdxW-1:0];
          issue_d   = issue_q + CntW'(1);
        end else begin
          priority case (item_q.operation)
            OP_LOOKUP: begin
              if (is_ascii) begin
                res_d.mapped = ValW'(item_q.key_in);
                state_d      = ST_RESP;
              end else begin
                lo_d    = '0;
                hi_d    = RomIdxW'(RomSize);
                state_d = ST_ROM;
              end
            end
            OP_ADD: begin
              if (used_q < CntW'(OVERRIDE_DEPTH)) begin
                src_we = 1'b1;
                tgt_we = 1'b1;
                used_d = used_q + CntW'(1);
              end else begin
                res_d.status = STAT_FULL;
              end
              state_d = ST_RESP;
            end
            default: begin
              res_d.status = STAT_MISS;
              state_d      = ST_RESP;
            end
          endcase
        end
      end

      ST_TGT: begin
        res_d.mapped = tgt_rdata;
        state_d      = ST_RESP;
      end

      ST_MOVE: begin
        src_we    = 1'b1;
        tgt_we    = 1'b1;
        src_waddr = hit_idx_q;
        tgt_waddr = hit_idx_q;
        src_wdata = src_rdata;
        tgt_wdata = tgt_rdata;
        used_d    = last;
        state_d   = ST_RESP;
      end

      ST_ROM: begin
        if (lo_q >= hi_q) begin
          res_d.status = STAT_MISS;
          state_d      = ST_RESP;
        end else if (RomSrc[mid] == item_q.key_in) begin
          res_d.mapped = RomDst[mid];
          state_d      = ST_RESP;
        end else if (RomSrc[mid] < item_q.key_in) begin
          lo_d = mid + RomIdxW'(1);
        end else begin
          hi_d = mid;
        end
      end

      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_d.mapped_key     = res_q.mapped;
      out_d.status         = res_q.status;
      out_d.override_count = used_ext[CountW-1:0];
      out_valid_d          = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(OVERRIDE_DEPTH))
    else $error("override count above table depth");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |->
      (used_q == $past(used_q) + CntW'(1) || used_q == $past(used_q) - CntW'(1) ||
       used_q == '0))
    else $error("override count moved by more than one entry");

  a_full_only_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res_q.status == STAT_FULL) |-> (used_q == CntW'(OVERRIDE_DEPTH)))
    else $error("full status while table has room");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_RESP) |-> (!src_we && !tgt_we))
    else $error("override RAM written outside an operation");

endmodule

/* tb/key_code_translation_table_tb.sv */
// Self-checking testbench for the key code translator: override edits, lookups, full table, random traffic.
module key_code_translation_table_tb;
  import kct_pkg::*;

  localparam int unsigned PrintLow  = 32;
  localparam int unsigned PrintHigh = 126;
  localparam int unsigned BaseGroup = 4194304;   // codes just above this hold the base table
  localparam int unsigned PadGroup  = 4194432;   // keypad part of the base table
  localparam int unsigned PoolSize  = 80;
  localparam int unsigned DrainWait = 100;
  localparam logic [7:0] PadOps [5] = '{8'h2A, 8'h2F, 8'h2D, 8'h2E, 8'h2B};

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  kct_in_t  in_i;
  logic     out_valid_o;
  logic     out_ready_i;
  kct_out_t out_o;

  // Own copy of the override table.
  logic [KeyW-1:0] remap_src [OverrideDepth];
  logic [ValW-1:0] remap_dst [OverrideDepth];
  int unsigned     remap_used;

  kct_out_t        pending_words [$];
  kct_out_t        oldest_word;
  logic [KeyW-1:0] key_pool [PoolSize];
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     mismatches;

  key_code_translation_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic int find_remap(input logic [KeyW-1:0] key);
    for (int unsigned i = 0; i < remap_used; i++) begin
      if (remap_src[i] == key) return int'(i);
    end
    return -1;
  endfunction

  // Fixed base table, in ranges of consecutive codes.
  function automatic bit base_code(input logic [KeyW-1:0] key, output logic [ValW-1:0] code);
    int k;
    int unsigned v;
    k = int'(key) - int'(BaseGroup);
    v = 0;
    if (k >= 1 && k <= 12) v = 32'h0100_0000 + k - 1;
    else if (k >= 13 && k <= 20) v = 32'h0100_0010 + k - 13;
    else if (k >= 21 && k <= 27) v = 32'h0100_0020 + k - 21;
    else if (k >= 28 && k <= 39) v = 32'h0100_0030 + k - 28;
    else if (k >= 129 && k <= 133) v = PadOps[k - 129];
    else if (k >= 134 && k <= 143) v = 32'h30 + k - 134;
    else begin
      code = '0;
      return 1'b0;
    end
    code = ValW'(v);
    return 1'b1;
  endfunction

  function automatic kct_out_t translate_and_update(input kct_in_t w);
    kct_out_t    r;
    int          hit;
    int unsigned last;
    r   = '0;
    hit = find_remap(w.key_in);
    case (op_e'(w.operation))
      OP_LOOKUP: begin
        if (hit >= 0) begin
          r.mapped_key = remap_dst[hit];
        end else if (w.key_in >= PrintLow && w.key_in <= PrintHigh) begin
          r.mapped_key = ValW'(w.key_in);
        end else if (!base_code(w.key_in, r.mapped_key)) begin
          r.status = STAT_MISS;
        end
      end
      OP_ADD: begin
        if (hit >= 0) begin
          remap_dst[hit] = w.new_value;
        end else if (remap_used < OverrideDepth) begin
          remap_src[remap_used] = w.key_in;
          remap_dst[remap_used] = w.new_value;
          remap_used++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          // fill the hole with the last entry
          last           = remap_used - 1;
          remap_src[hit] = remap_src[last];
          remap_dst[hit] = remap_dst[last];
          remap_used     = last;
        end else begin
          r.status = STAT_MISS;
        end
      end
      default: remap_used = 0;
    endcase
    r.override_count = CountW'(remap_used);
    return r;
  endfunction

  // Hold valid until the word is taken; valid stays high on return.
  task automatic send_word(input op_e op, input logic [KeyW-1:0] key,
                           input logic [ValW-1:0] value);
    kct_in_t w;
    w.operation = op;
    w.key_in    = key;
    w.new_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_words.push_back(translate_and_update(w));
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return OP_LOOKUP;
    if (r < 80) return OP_ADD;
    if (r < 98) return OP_REMOVE;
    return OP_CLEAR;
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return key_pool[$urandom_range(PoolSize - 1)];
    if (r < 55) return KeyW'($urandom_range(PrintHigh, PrintLow));
    if (r < 66) return KeyW'(BaseGroup + $urandom_range(40));
    if (r < 74) return KeyW'(PadGroup + $urandom_range(16));
    if (r < 80) return KeyW'($urandom_range(127));
    return KeyW'($urandom_range(23'h7F_FFFF));
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return ValW'($urandom_range(25'h1FF_FFFF));
  endfunction

  task automatic test_lookup_paths();
    send_word(OP_LOOKUP, KeyW'(0), '0);
    send_word(OP_LOOKUP, KeyW'(31), '0);
    send_word(OP_LOOKUP, KeyW'(32), '1);
    send_word(OP_LOOKUP, KeyW'(126), '0);
    send_word(OP_LOOKUP, KeyW'(127), '0);
    send_word(OP_LOOKUP, KeyW'(BaseGroup), '0);
    send_word(OP_LOOKUP, KeyW'(BaseGroup + 1), '0);
    send_word(OP_LOOKUP, KeyW'(BaseGroup + 39), '0);
    send_word(OP_LOOKUP, KeyW'(BaseGroup + 40), '0);
    send_word(OP_LOOKUP, KeyW'(PadGroup + 1), '0);
    send_word(OP_LOOKUP, KeyW'(PadGroup + 15), '0);
    send_word(OP_LOOKUP, KeyW'(PadGroup + 16), '0);
    send_word(OP_LOOKUP, '1, '1);
  endtask

  task automatic test_override_edits();
    send_word(OP_ADD, KeyW'(65), '1);
    send_word(OP_ADD, KeyW'(BaseGroup + 1), '0);
    send_word(OP_ADD, KeyW'(0), ValW'(25'h123_4567));
    send_word(OP_LOOKUP, KeyW'(65), '0);
    send_word(OP_LOOKUP, KeyW'(BaseGroup + 1), '0);
    send_word(OP_LOOKUP, KeyW'(0), '0);
    send_word(OP_ADD, KeyW'(65), '0);
    send_word(OP_REMOVE, KeyW'(65), '0);
    send_word(OP_LOOKUP, KeyW'(0), '0);
    send_word(OP_REMOVE, KeyW'(7), '0);
    send_word(OP_REMOVE, KeyW'(0), '0);
    send_word(OP_LOOKUP, KeyW'(65), '0);
    send_word(OP_CLEAR, '1, '1);
    send_word(OP_LOOKUP, KeyW'(BaseGroup + 1), '0);
  endtask

  // Fill every entry, push adds into the full table, then thin it out again.
  task automatic test_table_full();
    wait_for_drain();
    send_word(OP_CLEAR, pick_key(), pick_value());
    for (int unsigned i = 0; i < OverrideDepth; i++) begin
      send_word(OP_ADD, key_pool[i], pick_value());
      if ($urandom_range(99) < 25) send_word(OP_LOOKUP, key_pool[$urandom_range(i)], '0);
    end
    for (int unsigned i = 0; i < 30; i++) begin
      case ($urandom_range(2))
        0: send_word(OP_ADD, key_pool[$urandom_range(PoolSize - 1, OverrideDepth)],
                     pick_value());
        1: send_word(OP_ADD, key_pool[$urandom_range(OverrideDepth - 1)], pick_value());
        default: send_word(OP_LOOKUP, key_pool[$urandom_range(PoolSize - 1)], '0);
      endcase
    end
    send_word(OP_REMOVE, key_pool[0], '0);
    send_word(OP_REMOVE, key_pool[OverrideDepth - 1], '0);
    for (int unsigned i = 0; i < 30; i++) begin
      send_word($urandom_range(1) ? OP_REMOVE : OP_LOOKUP,
                key_pool[$urandom_range(PoolSize - 1)], pick_value());
    end
  endtask

  task automatic test_random_traffic(input int unsigned words);
    wait_for_drain();
    for (int unsigned i = 0; i < words; i++) begin
      send_word(pick_op(), pick_key(), pick_value());
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, mapped_key", out_o.mapped_key, '0);
      end else begin
        oldest_word = pending_words.pop_front();
        if (out_o.mapped_key !== oldest_word.mapped_key) begin
          report_mismatch("mapped_key", out_o.mapped_key, oldest_word.mapped_key);
        end
        if (out_o.status !== oldest_word.status) begin
          report_mismatch("status", out_o.status, oldest_word.status);
        end
        if (out_o.override_count !== oldest_word.override_count) begin
          report_mismatch("override_count", out_o.override_count,
                          oldest_word.override_count);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_i          = '0;
    out_ready_i   = 1'b0;
    remap_used    = 0;
    mismatches    = 0;
    send_idle_pct = 17;
    recv_idle_pct = 63;
    for (int unsigned i = 0; i < PoolSize; i++) begin
      key_pool[i] = {16'($urandom_range(16'hFFFF)), 7'(i)};
    end
    key_pool[0] = KeyW'(PrintLow);
    key_pool[1] = KeyW'(PrintHigh);
    key_pool[2] = KeyW'(BaseGroup + 1);
    key_pool[3] = KeyW'(PadGroup + 15);
    key_pool[4] = '0;
    key_pool[5] = '1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lookup_paths();
    test_override_edits();
    test_random_traffic(170);

    send_idle_pct = 63;
    recv_idle_pct = 17;
    test_table_full();
    test_random_traffic(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200);

    wait_for_drain();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/kct_pkg.sv
rtl/core/kct_ram.sv
rtl/core/key_code_translation_table.sv
tb/key_code_translation_table_tb.sv
